// ===== rtl/core/bsmmg_pkg.sv =====
package bsmmg_pkg;

  localparam int DEF_MAX_VALUES = 1024;
  localparam int VAL_W          = 32;
  localparam int CAP_W          = 11;
  localparam int CNT_OUT_W      = 11;
  localparam int MIN_FOR_SPANS  = 2;

  localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;
  localparam logic [VAL_W-1:0] GAP_INIT  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 status;
    logic                 spans_valid;
    logic [VAL_W-1:0]     shortest_span;
    logic [VAL_W-1:0]     longest_span;
    logic [CNT_OUT_W-1:0] stored_count;
  } res_t;

endpackage

// ===== rtl/core/bounded_set_min_max_gap.sv =====
// Bounded set of signed 32-bit values reporting the shortest and longest span between
// stored values after every add. Each item is accepted while the block is idle; an add
// compares the new value with every value already held, one read per cycle from the value
// memory. An accepted add into a non-empty set scans the held values, then writes the new
// value and offers its result to the output register; the first add into an empty set
// skips the scan, and a refused add goes straight to offering its result. The next item
// is taken only after that result has moved into the output register. A result waiting
// in the output register does not hold off the next item, only that item's own result.
// Capacity is clamped to MAX_VALUES; lowering it below the count refuses later adds until
// raised past the count again. Spans read zero while fewer than two values are held.
module bounded_set_min_max_gap #(
  parameter int MAX_VALUES = bsmmg_pkg::DEF_MAX_VALUES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [bsmmg_pkg::VAL_W-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_status,
  output logic                            out_spans_valid,
  output logic [bsmmg_pkg::VAL_W-1:0]     out_shortest_span,
  output logic [bsmmg_pkg::VAL_W-1:0]     out_longest_span,
  output logic [bsmmg_pkg::CNT_OUT_W-1:0] out_stored_count,
  input  logic                            cfg_wr_en,
  input  logic [bsmmg_pkg::CAP_W-1:0]     cfg_wr_data
);
  import bsmmg_pkg::*;

  localparam int AW = $clog2(MAX_VALUES);
  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [LW-1:0]    cap_ext;
  logic [CW-1:0]    limit;
  logic             out_valid_r;
  res_t             out_r;
  res_t             res;
  logic             res_vld;
  logic             res_take;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;

  assign cap_ext  = LW'(cap_r);
  assign limit    = (cap_ext > LW'(MAX_VALUES)) ? CW'(MAX_VALUES) : CW'(cap_ext);
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  bsmmg_ctrl #(
    .MAX_VALUES(MAX_VALUES),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .limit    (limit),
    .res_vld  (res_vld),
    .res_take (res_take),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  bsmmg_mem #(
    .DEPTH(MAX_VALUES),
    .AW   (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_spans_valid   = out_r.spans_valid;
  assign out_shortest_span = out_r.shortest_span;
  assign out_longest_span  = out_r.longest_span;
  assign out_stored_count  = out_r.stored_count;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous item still in progress");

  a_spans_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_spans_valid |-> out_shortest_span == '0 && out_longest_span == '0)
    else $error("spans nonzero with fewer than two values");

  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_spans_valid |-> out_shortest_span <= out_longest_span)
    else $error("shortest span exceeds longest span");
`endif

endmodule

// ===== rtl/core/bsmmg_mem.sv =====
module bsmmg_mem #(
  parameter int DEPTH = bsmmg_pkg::DEF_MAX_VALUES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [bsmmg_pkg::VAL_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [bsmmg_pkg::VAL_W-1:0] wr_data
);
  import bsmmg_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/bsmmg_ctrl.sv =====
module bsmmg_ctrl #(
  parameter int MAX_VALUES = bsmmg_pkg::DEF_MAX_VALUES,
  parameter int AW         = $clog2(MAX_VALUES),
  parameter int CW         = $clog2(MAX_VALUES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bsmmg_pkg::VAL_W-1:0] in_value,
  input  logic [CW-1:0]               limit,
  output logic                        res_vld,
  input  logic                        res_take,
  output bsmmg_pkg::res_t             res,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [bsmmg_pkg::VAL_W-1:0] rd_data,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [bsmmg_pkg::VAL_W-1:0] wr_data
);
  import bsmmg_pkg::*;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    scan_idx_r;
  logic [VAL_W-1:0] key_r;
  logic             status_r;
  logic [VAL_W-1:0] smallest_r;
  logic [VAL_W-1:0] largest_r;
  logic [VAL_W-1:0] min_gap_r;
  logic             rd_vld_r;
  logic             diff_vld_r;
  logic [VAL_W-1:0] diff_r;
  logic             accept;
  logic             fits;
  logic             spans_ok;

  assign accept   = in_valid && in_ready;
  assign fits     = count_r < limit;
  assign spans_ok = count_r >= CW'(MIN_FOR_SPANS);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!fits) begin
            state_nxt = ST_DONE;
          end else if (count_r == '0) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!rd_en && !rd_vld_r && !diff_vld_r) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    res_vld  = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  rd_en    = scan_idx_r != count_r;
      ST_WRITE: wr_en    = 1'b1;
      ST_DONE:  res_vld  = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign rd_addr = scan_idx_r[AW-1:0];
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      min_gap_r  <= GAP_INIT;
      rd_vld_r   <= 1'b0;
      diff_vld_r <= 1'b0;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= rd_en;
      diff_vld_r <= rd_vld_r;
      if (accept) begin
        scan_idx_r <= '0;
      end else if (rd_en) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (diff_vld_r && (diff_r < min_gap_r)) begin
        min_gap_r <= diff_r;
      end
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r    <= in_value ^ SIGN_FLIP;
      status_r <= !fits;
    end
    if (rd_vld_r) begin
      diff_r <= (rd_data > key_r) ? (rd_data - key_r) : (key_r - rd_data);
    end
    if (wr_en) begin
      if (count_r == '0) begin
        smallest_r <= key_r;
        largest_r  <= key_r;
      end else begin
        if (key_r < smallest_r) begin
          smallest_r <= key_r;
        end
        if (key_r > largest_r) begin
          largest_r <= key_r;
        end
      end
    end
  end

  always_comb begin
    res.status        = status_r;
    res.spans_valid   = spans_ok;
    res.shortest_span = spans_ok ? min_gap_r : '0;
    res.longest_span  = spans_ok ? (largest_r - smallest_r) : '0;
    res.stored_count  = CNT_OUT_W'(count_r);
  end

endmodule
